@@ design/lpdf_pkg.sv @@
`default_nettype none
package lpdf_pkg;

  localparam int unsigned LimitWidth = 17;
  localparam int unsigned LengthWidth = 16;
  localparam logic [LimitWidth-1:0] LimitMin = 17'd3;
  localparam logic [LimitWidth-1:0] LimitMax = 17'd131070;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  typedef enum logic [2:0] {
    PH_HDR_HI,
    PH_HDR_LO,
    PH_MARKER,
    PH_PAYLOAD,
    PH_SWALLOW
  } phase_t;

  // Clamp a written limit into the supported range.
  function automatic logic [LimitWidth-1:0] clamp_limit(input logic [LimitWidth-1:0] value);
    logic [LimitWidth-1:0] res;
    if (value < LimitMin) begin
      res = LimitMin;
    end else if (value > LimitMax) begin
      res = LimitMax;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ design/lpdf_if.sv @@
`default_nettype none
interface lpdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface lpdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last;
  logic       is_tcp;

  modport source (output valid, output payload_byte, output last, output is_tcp, input ready);
  modport sink (input valid, input payload_byte, input last, input is_tcp, output ready);
endinterface

interface lpdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] buffer_limit;

  modport source (output valid, output buffer_limit, input ready);
  modport sink (input valid, input buffer_limit, output ready);
endinterface
`default_nettype wire

@@ design/length_prefixed_datagram_deframer.sv @@
// A payload byte is registered and appears on tx in the cycle after its request is accepted on rx.
// Throughput: one byte per cycle; rx is ready whenever the tx output register is empty
// or being drained in the same cycle, so the output register sets the pace.
// Header, marker and swallowed bytes are consumed with no result.
// Reset (rst, synchronous, active high): parser awaits a header high byte, session
// unopened and UDP, counters zero, buffer limit 131070. Config writes are always ready.
`default_nettype none
module length_prefixed_datagram_deframer (
  input  wire logic clk,
  input  wire logic rst,
  lpdf_in_if.sink   rx,
  lpdf_out_if.source tx,
  lpdf_cfg_if.sink  cfg
);

  lpdf_pkg::phase_t phase, phase_next;
  logic [7:0]                          length_high, length_high_next;
  logic [lpdf_pkg::LengthWidth-1:0]    frame_length, frame_length_next;
  logic [lpdf_pkg::LimitWidth-1:0]     bytes_counted, bytes_counted_next;
  logic                                session_open, session_open_next;
  logic                                session_tcp, session_tcp_next;
  logic [lpdf_pkg::LimitWidth-1:0]     limit;

  logic                                rx_fire;
  logic [lpdf_pkg::LengthWidth-1:0]    hdr_len;
  logic [lpdf_pkg::LimitWidth-1:0]     count_inc;
  logic                                frame_bad;
  logic                                payload_done;
  logic                                swallow_done;
  logic                                marker_ok;
  logic                                out_load;
  logic                                out_last_next;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !tx.valid || tx.ready;
  assign rx_fire   = rx.valid && rx.ready;

  assign hdr_len      = {length_high, rx.data_byte};
  assign count_inc    = bytes_counted + 17'd1;
  assign frame_bad    = (hdr_len == '0) ||
                        ({1'b0, hdr_len} >= limit);
  assign payload_done = count_inc >= {1'b0, frame_length};
  // count + 1 >= limit + 1, with no wrap since count never passes the limit
  assign swallow_done = bytes_counted >= limit;
  assign marker_ok    = (rx.data_byte == lpdf_pkg::ProtoTcp) ||
                        (rx.data_byte == lpdf_pkg::ProtoUdp);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (rx_fire) begin
      case (phase)
        lpdf_pkg::PH_HDR_HI: phase_next = lpdf_pkg::PH_HDR_LO;
        lpdf_pkg::PH_HDR_LO: begin
          if (!session_open && hdr_len == '0) begin
            phase_next = lpdf_pkg::PH_MARKER;
          end else if (frame_bad) begin
            phase_next = lpdf_pkg::PH_SWALLOW;
          end else begin
            phase_next = lpdf_pkg::PH_PAYLOAD;
          end
        end
        lpdf_pkg::PH_MARKER: phase_next = lpdf_pkg::PH_HDR_HI;
        lpdf_pkg::PH_PAYLOAD: begin
          if (payload_done) phase_next = lpdf_pkg::PH_HDR_HI;
        end
        lpdf_pkg::PH_SWALLOW: begin
          if (swallow_done) phase_next = lpdf_pkg::PH_HDR_HI;
        end
        default: phase_next = lpdf_pkg::PH_HDR_HI;
      endcase
    end
  end

  // Datapath and outputs
  always_comb begin
    length_high_next   = length_high;
    frame_length_next  = frame_length;
    bytes_counted_next = bytes_counted;
    session_open_next  = session_open;
    session_tcp_next   = session_tcp;
    out_load           = 1'b0;
    out_last_next      = 1'b0;
    if (rx_fire) begin
      case (phase)
        lpdf_pkg::PH_HDR_HI: length_high_next = rx.data_byte;
        lpdf_pkg::PH_HDR_LO: begin
          frame_length_next = hdr_len;
          if (session_open || hdr_len != '0) begin
            if (!session_open) begin
              session_open_next = 1'b1;
              session_tcp_next  = 1'b0;
            end
            bytes_counted_next = frame_bad ? 17'd2 : '0;
          end
        end
        lpdf_pkg::PH_MARKER: begin
          if (marker_ok) begin
            session_open_next = 1'b1;
            session_tcp_next  = (rx.data_byte == lpdf_pkg::ProtoTcp);
          end
        end
        lpdf_pkg::PH_PAYLOAD: begin
          out_load           = 1'b1;
          out_last_next      = payload_done;
          bytes_counted_next = payload_done ? '0 : count_inc;
        end
        lpdf_pkg::PH_SWALLOW: begin
          bytes_counted_next = swallow_done ? '0 : count_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lpdf_pkg::PH_HDR_HI;
      length_high   <= '0;
      frame_length  <= '0;
      bytes_counted <= '0;
      session_open  <= 1'b0;
      session_tcp   <= 1'b0;
      limit         <= lpdf_pkg::LimitMax;
      tx.valid      <= 1'b0;
    end else begin
      phase         <= phase_next;
      length_high   <= length_high_next;
      frame_length  <= frame_length_next;
      bytes_counted <= bytes_counted_next;
      session_open  <= session_open_next;
      session_tcp   <= session_tcp_next;
      if (cfg.valid) limit <= lpdf_pkg::clamp_limit(cfg.buffer_limit);
      if (out_load) begin
        tx.valid <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      tx.payload_byte <= rx.data_byte;
      tx.last         <= out_last_next;
      tx.is_tcp       <= session_tcp;
    end
  end

  a_tcp_needs_open: assert property (@(posedge clk) disable iff (rst)
    session_tcp |-> session_open)
    else $error("TCP session flagged while unopened");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == lpdf_pkg::PH_PAYLOAD) |-> (bytes_counted < {1'b0, frame_length}))
    else $error("payload count reached frame length");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last_next) |=> (phase == lpdf_pkg::PH_HDR_HI && tx.valid && tx.last))
    else $error("last byte did not return parser to header");

  a_limit_range: assert property (@(posedge clk) disable iff (rst)
    (limit >= lpdf_pkg::LimitMin) && (limit <= lpdf_pkg::LimitMax))
    else $error("buffer limit out of range");

endmodule
`default_nettype wire

@@ tb/deframer_checker.sv @@
module deframer_checker
  import lpdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lpdf_in_if          rx,
  lpdf_out_if         tx,
  lpdf_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned delivered
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       tcp;
  } payload_beat_t;

  payload_beat_t          expected_beats[$];
  phase_t                 parse_phase;
  logic [7:0]             len_hi;
  logic [LengthWidth-1:0] cur_len;
  logic [LimitWidth-1:0]  counted;
  logic                   session_up;
  logic                   session_is_tcp;
  logic [LimitWidth-1:0]  limit_reg;

  function automatic int unsigned usable_limit();
    int unsigned raw;
    raw = limit_reg;
    return (raw < LimitMin) ? LimitMin : ((raw > LimitMax) ? LimitMax : raw);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches += 1;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Advance the parser by one stream byte; queue the payload byte it yields, if any.
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0]   hdr;
    payload_beat_t beat;
    case (parse_phase)
      PH_HDR_HI: begin
        len_hi = b;
        parse_phase = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        hdr = {len_hi, b};
        if (!session_up && hdr == 16'h0000) begin
          cur_len = '0;
          parse_phase = PH_MARKER;
        end else begin
          // first nonzero header opens the session as UDP and is a frame itself
          if (!session_up) begin
            session_up = 1'b1;
            session_is_tcp = 1'b0;
          end
          cur_len = hdr;
          if (hdr == 16'h0000 || hdr >= usable_limit()) begin
            counted = 17'd2;
            parse_phase = PH_SWALLOW;
          end else begin
            counted = '0;
            parse_phase = PH_PAYLOAD;
          end
        end
      end
      PH_MARKER: begin
        if (b == ProtoTcp || b == ProtoUdp) begin
          session_up = 1'b1;
          session_is_tcp = (b == ProtoTcp);
        end
        parse_phase = PH_HDR_HI;
      end
      PH_PAYLOAD: begin
        counted = counted + 17'd1;
        beat.data = b;
        beat.last = (counted >= cur_len);
        beat.tcp = session_is_tcp;
        expected_beats.push_back(beat);
        if (beat.last) begin
          counted = '0;
          parse_phase = PH_HDR_HI;
        end
      end
      PH_SWALLOW: begin
        counted = counted + 17'd1;
        if (counted >= usable_limit() + 1) begin
          counted = '0;
          parse_phase = PH_HDR_HI;
        end
      end
      default: parse_phase = PH_HDR_HI;
    endcase
  endtask

  always @(posedge clk) begin
    payload_beat_t want;
    if (rst) begin
      expected_beats.delete();
      parse_phase = PH_HDR_HI;
      len_hi = '0;
      cur_len = '0;
      counted = '0;
      session_up = 1'b0;
      session_is_tcp = 1'b0;
      limit_reg = LimitMax;
      mismatches = 0;
      delivered = 0;
    end else begin
      // compare before queueing this edge's request so an early result is caught
      if (tx.valid && tx.ready) begin
        delivered += 1;
        if (expected_beats.size() == 0) begin
          note_mismatch($sformatf("unexpected payload byte %02h last %0b tcp %0b",
                                  tx.payload_byte, tx.last, tx.is_tcp));
        end else begin
          want = expected_beats.pop_front();
          if (want.data !== tx.payload_byte || want.last !== tx.last ||
              want.tcp !== tx.is_tcp) begin
            note_mismatch($sformatf(
                "payload mismatch: expected byte %02h last %0b tcp %0b, got %02h %0b %0b",
                want.data, want.last, want.tcp, tx.payload_byte, tx.last, tx.is_tcp));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        limit_reg = cfg.buffer_limit;
      end
      if (rx.valid && rx.ready) begin
        deframe_byte(rx.data_byte);
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import lpdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBytes = 210;

  typedef enum int {
    FLOW_STEADY,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_mix_t;

  typedef enum int {
    OPEN_BY_TCP_MARKER,
    OPEN_BY_UDP_MARKER,
    OPEN_BY_FRAME
  } opening_t;

  logic clk = 1'b0;
  logic rst;

  lpdf_in_if  rx_ch ();
  lpdf_out_if tx_ch ();
  lpdf_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned delivered;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned bytes_sent = 0;
  int unsigned limit_writes = 0;
  int unsigned active_limit = LimitMax;
  int unsigned quiet_cycles = 0;

  length_prefixed_datagram_deframer u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch),
    .cfg (cfg_ch)
  );

  deframer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .tx          (tx_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .delivered   (delivered)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("no request moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is requested.
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    tx_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        tx_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      tx_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_flow(input flow_mix_t mix);
    case (mix)
      FLOW_STEADY:          begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      FLOW_SENDER_GAPS:     begin send_idle_pct = 53; recv_stall_pct = 0;  end
      FLOW_RECEIVER_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default:              begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  task automatic put_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.data_byte <= value;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent += 1;
    @(negedge clk);
  endtask

  task automatic put_frame(input logic [15:0] len);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    repeat (len) put_byte(8'($urandom_range(255)));
  endtask

  // Header that gets swallowed, then filler up to limit+1 counted bytes.
  task automatic put_discard(input logic [15:0] hdr);
    put_byte(hdr[15:8]);
    put_byte(hdr[7:0]);
    repeat (active_limit - 1) put_byte(8'($urandom_range(255)));
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [16:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.buffer_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    active_limit = (value < LimitMin) ? LimitMin : ((value > LimitMax) ? LimitMax : value);
    limit_writes += 1;
  endtask

  task automatic random_frame();
    int unsigned roll;
    int unsigned cap;
    int unsigned len;
    roll = $urandom_range(99);
    cap = active_limit - 1;
    if (active_limit <= 400 && roll >= 88) begin
      put_discard(16'($urandom_range(65535, active_limit)));
    end else if (active_limit <= 400 && roll >= 76) begin
      put_discard(16'h0000);
    end else begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range((cap < 300) ? cap : 300, 1);
      end else begin
        len = $urandom_range((cap < 12) ? cap : 12, 1);
      end
      put_frame(16'(len));
    end
  endtask

  initial begin
    opening_t    opening;
    logic [16:0] limit_plan [8];
    int unsigned phase_end;
    int unsigned phase_start;
    bit          did_hold;
    bit          did_drain;

    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.data_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.buffer_limit <= '0;
    did_hold = 1'b0;
    did_drain = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: rejected marker, session opening, then edge frames.
    set_flow(FLOW_STEADY);
    put_byte(8'h00); put_byte(8'h00); put_byte(8'hFF);
    opening = opening_t'($urandom_range(2));
    case (opening)
      OPEN_BY_TCP_MARKER: begin put_byte(8'h00); put_byte(8'h00); put_byte(ProtoTcp); end
      OPEN_BY_UDP_MARKER: begin put_byte(8'h00); put_byte(8'h00); put_byte(ProtoUdp); end
      default:            begin put_byte(8'h00); put_byte(8'h01); put_byte(8'hFF); end
    endcase
    put_byte(8'h00); put_byte(8'h01); put_byte(8'h00);
    put_byte(8'h00); put_byte(8'h02); put_byte(8'hFF); put_byte(8'h00);
    // below-range limit acts as the minimum
    set_limit(17'd0);
    put_byte(8'h00); put_byte(8'h02); put_byte(8'hFF); put_byte(8'h80);
    put_discard(16'd3);
    put_discard(16'h0000);
    put_discard(16'hFFFF);

    limit_plan[0] = LimitMax;
    limit_plan[1] = LimitMin;
    limit_plan[2] = 17'h1FFFF;
    limit_plan[3] = 17'd1;
    limit_plan[4] = 17'($urandom_range(400, 41));
    limit_plan[5] = 17'd2;
    limit_plan[6] = 17'($urandom_range(40, 4));
    limit_plan[7] = 17'd0;

    for (int p = 0; p < 8; p++) begin
      set_limit(limit_plan[p]);
      set_flow(flow_mix_t'(p % 4));
      phase_start = bytes_sent;
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        if (p == 0 && !did_hold && bytes_sent >= phase_start + 40) begin
          // hold the receiver while requests keep coming
          hold_requests += 1;
          did_hold = 1'b1;
        end
        if (p == 5 && !did_drain && bytes_sent >= phase_start + 80) begin
          settle();
          did_drain = 1'b1;
        end
        random_frame();
      end
    end

    rx_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Streamed %0d bytes, checked %0d payload bytes over %0d limit writes.",
             bytes_sent, delivered, limit_writes);
    $display("Session opened by %s; all four sender/receiver gap mixes exercised.",
             opening.name());
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d payload bytes never delivered", mismatches, outstanding);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ length_prefixed_datagram_deframer.f @@
design/lpdf_pkg.sv
design/lpdf_if.sv
design/length_prefixed_datagram_deframer.sv
tb/deframer_checker.sv
tb/tb.sv
